// ===== hdl/nns_pkg.sv =====
// Shared types and constants of the nearest-neighbor scaler.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package nns_pkg;

    localparam int MAX_DIMENSION = 2048;
    localparam int STORE_PIXELS  = 1048576;
    localparam int FRACTION_BITS = 16;

    localparam int SIZE_W  = $clog2(MAX_DIMENSION) + 1;
    localparam int COORD_W = $clog2(MAX_DIMENSION);
    localparam int PIXEL_W = 24;
    localparam int INDEX_W = 20;
    localparam int ROW_W   = 2 * SIZE_W;
    localparam int WIDE_W  = 2 * SIZE_W + 1;
    localparam int REG_IDX_W = 2;

    localparam int RESET_SOURCE_WIDTH  = 1152;
    localparam int RESET_SOURCE_HEIGHT = 864;
    localparam int RESET_TARGET_WIDTH  = 1920;
    localparam int RESET_TARGET_HEIGHT = 1080;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } t_op;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_WIDTH  = 2'd2,
        REG_TARGET_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_op                 op;
        logic                err;
        logic [INDEX_W-1:0]  load_index;
        logic [PIXEL_W-1:0]  pixel;
        logic [SIZE_W-1:0]   mx;
        logic [SIZE_W-1:0]   my;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

// ===== hdl/nearest_neighbor_scaler.sv =====
// Top level of the nearest-neighbor scaler: size registers, step dividers,
// front end, queue and back end. Depends on nns_pkg and all hdl/nns_* modules.
//
//  channel   handshake                     beat contents
//  command   start / busy                  i_operation, i_load_index, i_target_x/y, i_pixel_in
//  result    o_strobe (no backpressure)    o_pixel_out, o_mapped_x/y, o_range_error
//  config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One command beat per cycle while busy is low. A fetch result is registered in the queue
// slot, then in r_s1 and r_s2 of the back end, before o_strobe. A config write reruns the
// bit-serial step dividers, one quotient bit a cycle; busy is high and o_cfg_ready low until
// both finish. Synchronous active-low reset restores the default sizes and steps at once.
// The frame store is not cleared; the result side is never stalled.
module nearest_neighbor_scaler #(
    parameter int STORE_PIXELS  = nns_pkg::STORE_PIXELS,
    parameter int FRACTION_BITS = nns_pkg::FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [nns_pkg::INDEX_W-1:0]   i_load_index,
    input  logic [nns_pkg::COORD_W-1:0]   i_target_x,
    input  logic [nns_pkg::COORD_W-1:0]   i_target_y,
    input  logic [nns_pkg::PIXEL_W-1:0]   i_pixel_in,
    output logic                          o_strobe,
    output logic [nns_pkg::PIXEL_W-1:0]   o_pixel_out,
    output logic [nns_pkg::COORD_W-1:0]   o_mapped_x,
    output logic [nns_pkg::COORD_W-1:0]   o_mapped_y,
    output logic                          o_range_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nns_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [nns_pkg::SIZE_W-1:0]    i_cfg_data
);
    localparam int SW = nns_pkg::SIZE_W;
    localparam int QW = SW + FRACTION_BITS;

    logic [SW-1:0] r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic [SW-1:0] n_src_w, n_src_h, n_tgt_w, n_tgt_h;

    logic                   w_cfg_wr;
    logic                   w_accept;
    logic                   w_hdiv_busy, w_vdiv_busy;
    logic [QW-1:0]          w_hstep, w_vstep;
    logic                   w_push, w_pop;
    nns_pkg::t_item         w_front_item, w_head_item;
    nns_pkg::t_queue_status w_qstat;

    assign o_cfg_ready = !(w_hdiv_busy || w_vdiv_busy);
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign busy        = w_hdiv_busy || w_vdiv_busy || w_qstat.full;
    assign w_accept    = start && !busy;

    always_comb begin
        n_src_w = r_src_w;
        n_src_h = r_src_h;
        n_tgt_w = r_tgt_w;
        n_tgt_h = r_tgt_h;
        if (w_cfg_wr) begin
            case (nns_pkg::t_reg_idx'(i_cfg_index))
                nns_pkg::REG_SOURCE_WIDTH:  n_src_w = i_cfg_data;
                nns_pkg::REG_SOURCE_HEIGHT: n_src_h = i_cfg_data;
                nns_pkg::REG_TARGET_WIDTH:  n_tgt_w = i_cfg_data;
                nns_pkg::REG_TARGET_HEIGHT: n_tgt_h = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SW'(nns_pkg::RESET_SOURCE_WIDTH);
            r_src_h <= SW'(nns_pkg::RESET_SOURCE_HEIGHT);
            r_tgt_w <= SW'(nns_pkg::RESET_TARGET_WIDTH);
            r_tgt_h <= SW'(nns_pkg::RESET_TARGET_HEIGHT);
        end else begin
            r_src_w <= n_src_w;
            r_src_h <= n_src_h;
            r_tgt_w <= n_tgt_w;
            r_tgt_h <= n_tgt_h;
        end
    end

    nns_step_div #(
        .FRACTION_BITS (FRACTION_BITS),
        .RESET_SRC     (nns_pkg::RESET_SOURCE_WIDTH),
        .RESET_DST     (nns_pkg::RESET_TARGET_WIDTH),
        .QW            (QW)
    ) u_hdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cfg_wr),
        .i_src   (n_src_w),
        .i_dst   (n_tgt_w),
        .o_busy  (w_hdiv_busy),
        .o_step  (w_hstep)
    );

    nns_step_div #(
        .FRACTION_BITS (FRACTION_BITS),
        .RESET_SRC     (nns_pkg::RESET_SOURCE_HEIGHT),
        .RESET_DST     (nns_pkg::RESET_TARGET_HEIGHT),
        .QW            (QW)
    ) u_vdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cfg_wr),
        .i_src   (n_src_h),
        .i_dst   (n_tgt_h),
        .o_busy  (w_vdiv_busy),
        .o_step  (w_vstep)
    );

    nns_front #(
        .FRACTION_BITS (FRACTION_BITS),
        .QW            (QW)
    ) u_front (
        .i_accept        (w_accept),
        .i_operation     (i_operation),
        .i_load_index    (i_load_index),
        .i_target_x      (i_target_x),
        .i_target_y      (i_target_y),
        .i_pixel_in      (i_pixel_in),
        .i_hstep         (w_hstep),
        .i_vstep         (w_vstep),
        .i_target_width  (r_tgt_w),
        .i_target_height (r_tgt_h),
        .o_push          (w_push),
        .o_item          (w_front_item)
    );

    nns_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_qstat)
    );

    nns_back #(
        .STORE_PIXELS (STORE_PIXELS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (!w_qstat.empty),
        .i_item         (w_head_item),
        .i_source_width (r_src_w),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_pixel_out    (o_pixel_out),
        .o_mapped_x     (o_mapped_x),
        .o_mapped_y     (o_mapped_y),
        .o_range_error  (o_range_error)
    );

    a_fetch_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == nns_pkg::OP_FETCH) |-> ##3 o_strobe)
        else $error("fetch beat did not produce a result in 3 cycles");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == nns_pkg::OP_LOAD) |-> ##3 !o_strobe)
        else $error("load beat produced a result");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_range_error) |->
        (o_pixel_out == '0 && o_mapped_x == '0 && o_mapped_y == '0))
        else $error("range error result carries nonzero payload");

    a_cfg_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (busy && !o_cfg_ready))
        else $error("config write did not start step recalculation");

endmodule

// ===== hdl/nns_step_div.sv =====
// Bit-serial restoring divider producing one fixed-point step ratio.
// Uses nns_pkg for size widths; one quotient bit per cycle.
module nns_step_div #(
    parameter int FRACTION_BITS = nns_pkg::FRACTION_BITS,
    parameter int RESET_SRC     = nns_pkg::RESET_SOURCE_WIDTH,
    parameter int RESET_DST     = nns_pkg::RESET_TARGET_WIDTH,
    parameter int QW            = nns_pkg::SIZE_W + FRACTION_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [nns_pkg::SIZE_W-1:0] i_src,
    input  logic [nns_pkg::SIZE_W-1:0] i_dst,
    output logic                      o_busy,
    output logic [QW-1:0]             o_step
);
    localparam int SW = nns_pkg::SIZE_W;
    localparam int CW = $clog2(QW + 1);
    localparam logic [QW-1:0] RESET_STEP =
        QW'((longint'(RESET_SRC) << FRACTION_BITS) / longint'(RESET_DST));

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [QW-1:0] r_num;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_den;
    logic [QW-1:0] r_quo;
    logic [QW-1:0] r_step;

    logic [SW:0]   w_trial;
    logic          w_qbit;
    logic [SW:0]   w_diff;

    assign w_trial = {r_rem, r_num[QW-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_step <= RESET_STEP;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_step <= {r_quo[QW-2:0], w_qbit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_src, {FRACTION_BITS{1'b0}}};
            r_den <= (i_dst == '0) ? SW'(1) : i_dst;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[QW-2:0], 1'b0};
            r_rem <= w_qbit ? w_diff[SW-1:0] : w_trial[SW-1:0];
            r_quo <= {r_quo[QW-2:0], w_qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_step = r_step;

endmodule

// ===== hdl/nns_front.sv =====
// Front end: classifies each accepted beat, checks the destination range
// and maps the coordinate to the source grid. Uses nns_pkg types.
module nns_front #(
    parameter int FRACTION_BITS = nns_pkg::FRACTION_BITS,
    parameter int QW            = nns_pkg::SIZE_W + FRACTION_BITS
) (
    input  logic                        i_accept,
    input  logic                        i_operation,
    input  logic [nns_pkg::INDEX_W-1:0] i_load_index,
    input  logic [nns_pkg::COORD_W-1:0] i_target_x,
    input  logic [nns_pkg::COORD_W-1:0] i_target_y,
    input  logic [nns_pkg::PIXEL_W-1:0] i_pixel_in,
    input  logic [QW-1:0]               i_hstep,
    input  logic [QW-1:0]               i_vstep,
    input  logic [nns_pkg::SIZE_W-1:0]  i_target_width,
    input  logic [nns_pkg::SIZE_W-1:0]  i_target_height,
    output logic                        o_push,
    output nns_pkg::t_item              o_item
);
    localparam int SW = nns_pkg::SIZE_W;
    localparam int PW = nns_pkg::COORD_W + QW;

    logic [PW-1:0] w_px;
    logic [PW-1:0] w_py;
    logic          w_err;

    assign w_px  = PW'(i_target_x) * PW'(i_hstep);
    assign w_py  = PW'(i_target_y) * PW'(i_vstep);
    assign w_err = (SW'(i_target_x) >= i_target_width) ||
                   (SW'(i_target_y) >= i_target_height);

    always_comb begin
        o_item.op         = nns_pkg::t_op'(i_operation);
        o_item.err        = w_err;
        o_item.load_index = i_load_index;
        o_item.pixel      = i_pixel_in;
        o_item.mx         = w_err ? '0 : w_px[FRACTION_BITS +: SW];
        o_item.my         = w_err ? '0 : w_py[FRACTION_BITS +: SW];
    end

    assign o_push = i_accept;

endmodule

// ===== hdl/nns_queue.sv =====
// Short register queue between the front end and the back end.
// Uses nns_pkg for the item type and depth.
module nns_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  nns_pkg::t_item         i_item,
    input  logic                   i_pop,
    output nns_pkg::t_item         o_item,
    output nns_pkg::t_queue_status o_status
);
    localparam int DEPTH = nns_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    nns_pkg::t_item   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign w_do_push = i_push && (r_count != CNT_W'(DEPTH));
    assign w_do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_slot[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));

endmodule

// ===== hdl/nns_back.sv =====
// Back end: forms the source address, writes loads into the frame store
// and reads it for fetches. Uses nns_pkg types; holds the frame store memory.
module nns_back #(
    parameter int STORE_PIXELS = nns_pkg::STORE_PIXELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  nns_pkg::t_item              i_item,
    input  logic [nns_pkg::SIZE_W-1:0]  i_source_width,
    output logic                        o_pop,
    output logic                        o_strobe,
    output logic [nns_pkg::PIXEL_W-1:0] o_pixel_out,
    output logic [nns_pkg::COORD_W-1:0] o_mapped_x,
    output logic [nns_pkg::COORD_W-1:0] o_mapped_y,
    output logic                        o_range_error
);
    localparam int AW = $clog2(STORE_PIXELS);
    localparam int WW = nns_pkg::WIDE_W;
    localparam int RW = nns_pkg::ROW_W;
    localparam int CW = nns_pkg::COORD_W;

    logic [nns_pkg::PIXEL_W-1:0] r_mem [STORE_PIXELS];

    logic           r_s1_valid;
    nns_pkg::t_item r_s1;
    logic [RW-1:0]  r_row;

    logic           r_s2_valid;
    logic           r_s2_zero;
    logic           r_s2_err;
    logic [CW-1:0]  r_s2_mx;
    logic [CW-1:0]  r_s2_my;
    logic [nns_pkg::PIXEL_W-1:0] r_rd;

    logic [RW-1:0]  n_row;
    logic [WW-1:0]  w_addr;
    logic           w_in_store;
    logic           w_we;
    logic           w_fetch;

    assign n_row      = RW'(i_item.my) * RW'(i_source_width);
    assign w_addr     = WW'(r_row) + WW'(r_s1.mx);
    assign w_in_store = (w_addr < WW'(STORE_PIXELS));
    assign w_fetch    = r_s1_valid && (r_s1.op == nns_pkg::OP_FETCH);
    assign w_we       = r_s1_valid && (r_s1.op == nns_pkg::OP_LOAD) &&
                        (WW'(r_s1.load_index) < WW'(STORE_PIXELS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= w_fetch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1      <= i_item;
        r_row     <= n_row;
        r_s2_zero <= r_s1.err || !w_in_store;
        r_s2_err  <= r_s1.err;
        r_s2_mx   <= r_s1.mx[CW-1:0];
        r_s2_my   <= r_s1.my[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[AW'(r_s1.load_index)] <= r_s1.pixel;
        end else begin
            r_rd <= r_mem[w_addr[AW-1:0]];
        end
    end

    assign o_pop         = i_valid;
    assign o_strobe      = r_s2_valid;
    assign o_pixel_out   = r_s2_zero ? '0 : r_rd;
    assign o_mapped_x    = r_s2_mx;
    assign o_mapped_y    = r_s2_my;
    assign o_range_error = r_s2_err;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for nearest_neighbor_scaler: pixel loads, scaled fetches
// and size register writes, predicted with 12.16 step ratios. Needs nns_pkg.
module testbench;
    import nns_pkg::*;

    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic [COORD_W-1:0] mapped_x;
        logic [COORD_W-1:0] mapped_y;
        logic               range_error;
    } t_scaled_pixel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_operation = OP_LOAD;
    logic [INDEX_W-1:0]   i_load_index = '0;
    logic [COORD_W-1:0]   i_target_x = '0;
    logic [COORD_W-1:0]   i_target_y = '0;
    logic [PIXEL_W-1:0]   i_pixel_in = '0;
    logic                 o_strobe;
    logic [PIXEL_W-1:0]   o_pixel_out;
    logic [COORD_W-1:0]   o_mapped_x;
    logic [COORD_W-1:0]   o_mapped_y;
    logic                 o_range_error;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [REG_IDX_W-1:0] i_cfg_index = '0;
    logic [SIZE_W-1:0]    i_cfg_data = '0;

    logic [SIZE_W-1:0]    source_cols = SIZE_W'(RESET_SOURCE_WIDTH);
    logic [SIZE_W-1:0]    source_rows = SIZE_W'(RESET_SOURCE_HEIGHT);
    logic [SIZE_W-1:0]    tgt_width = SIZE_W'(RESET_TARGET_WIDTH);
    logic [SIZE_W-1:0]    tgt_height = SIZE_W'(RESET_TARGET_HEIGHT);
    longint unsigned      h_step;
    longint unsigned      v_step;
    logic [PIXEL_W-1:0]   source_image [longint unsigned];
    t_scaled_pixel        pending_pixels [$];
    t_scaled_pixel        oldest_pixel;
    int                   mismatch_count = 0;
    bit                   steady = 1'b0;

    nearest_neighbor_scaler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_load_index  (i_load_index),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_pixel_in    (i_pixel_in),
        .o_strobe      (o_strobe),
        .o_pixel_out   (o_pixel_out),
        .o_mapped_x    (o_mapped_x),
        .o_mapped_y    (o_mapped_y),
        .o_range_error (o_range_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned step_ratio(input logic [SIZE_W-1:0] src,
                                                   input logic [SIZE_W-1:0] dst);
        longint unsigned den;
        den = (dst == 0) ? 64'd1 : 64'(dst);
        return (64'(src) << FRACTION_BITS) / den;
    endfunction

    initial begin
        h_step = step_ratio(source_cols, tgt_width);
        v_step = step_ratio(source_rows, tgt_height);
    end

    function automatic bit map_to_source(input logic [COORD_W-1:0] tx,
                                         input logic [COORD_W-1:0] ty,
                                         output longint unsigned mx,
                                         output longint unsigned my,
                                         output longint unsigned addr);
        mx = (64'(tx) * h_step) >> FRACTION_BITS;
        my = (64'(ty) * v_step) >> FRACTION_BITS;
        addr = my * 64'(source_cols) + mx;
        return (tx < tgt_width) && (ty < tgt_height);
    endfunction

    function automatic void predict_scaled_pixel(input t_op op,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic [COORD_W-1:0] tx,
                                                 input logic [COORD_W-1:0] ty,
                                                 input logic [PIXEL_W-1:0] pix);
        t_scaled_pixel   expected;
        longint unsigned mx, my, addr;
        if (op == OP_LOAD) begin
            source_image[64'(idx)] = pix;
            return;
        end
        expected = '{pixel: '0, mapped_x: '0, mapped_y: '0, range_error: 1'b0};
        if (!map_to_source(tx, ty, mx, my, addr)) begin
            expected.range_error = 1'b1;
        end else begin
            expected.pixel = (addr < STORE_PIXELS) ? source_image[addr] : '0;
            expected.mapped_x = COORD_W'(mx);
            expected.mapped_y = COORD_W'(my);
        end
        pending_pixels.push_back(expected);
    endfunction

    function automatic void check_field(input string name, input longint unsigned expected,
                                        input longint unsigned actual);
        if (expected != actual) begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel_out: expected none, got %0h", o_pixel_out);
                mismatch_count++;
            end else begin
                oldest_pixel = pending_pixels.pop_front();
                check_field("pixel_out", oldest_pixel.pixel, o_pixel_out);
                check_field("mapped_x", oldest_pixel.mapped_x, o_mapped_x);
                check_field("mapped_y", oldest_pixel.mapped_y, o_mapped_y);
                check_field("range_error", oldest_pixel.range_error, o_range_error);
            end
        end
    end

    task automatic send_beat(input t_op op, input logic [INDEX_W-1:0] idx,
                             input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty,
                             input logic [PIXEL_W-1:0] pix);
        int gap;
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_load_index <= idx;
        i_target_x <= tx;
        i_target_y <= ty;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (busy);
        predict_scaled_pixel(op, idx, tx, ty, pix);
    endtask

    task automatic load_pixel(input logic [INDEX_W-1:0] idx, input logic [PIXEL_W-1:0] pix);
        send_beat(OP_LOAD, idx, COORD_W'($urandom), COORD_W'($urandom), pix);
    endtask

    // load the mapped source pixel first when it has never been written
    task automatic fetch_pixel(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
        longint unsigned mx, my, addr;
        if (map_to_source(tx, ty, mx, my, addr) && addr < STORE_PIXELS
                && !source_image.exists(addr))
            load_pixel(INDEX_W'(addr), PIXEL_W'($urandom));
        send_beat(OP_FETCH, INDEX_W'($urandom), tx, ty, PIXEL_W'($urandom));
    endtask

    task automatic program_size(input t_reg_idx idx, input logic [SIZE_W-1:0] value);
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  source_cols = value;
            REG_SOURCE_HEIGHT: source_rows = value;
            REG_TARGET_WIDTH:  tgt_width = value;
            REG_TARGET_HEIGHT: tgt_height = value;
            default: ;
        endcase
        h_step = step_ratio(source_cols, tgt_width);
        v_step = step_ratio(source_rows, tgt_height);
    endtask

    task automatic set_sizes(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                             input logic [SIZE_W-1:0] tw, input logic [SIZE_W-1:0] th);
        program_size(REG_SOURCE_WIDTH, sw);
        program_size(REG_SOURCE_HEIGHT, sh);
        program_size(REG_TARGET_WIDTH, tw);
        program_size(REG_TARGET_HEIGHT, th);
    endtask

    task automatic test_reset_sizes();
        fetch_pixel(11'd0, 11'd0);
        fetch_pixel(11'd1919, 11'd1079);
        fetch_pixel(11'd1920, 11'd0);
        fetch_pixel(11'd0, 11'd1080);
        fetch_pixel(11'd2047, 11'd2047);
    endtask

    task automatic test_field_extremes();
        set_sizes(12'd1024, 12'd1024, 12'd1024, 12'd1024);
        load_pixel('0, '0);
        load_pixel('1, '1);
        fetch_pixel(11'd0, 11'd0);
        fetch_pixel(11'd1023, 11'd1023);
        fetch_pixel(11'd2047, 11'd2047);
        // mapped position wider than the port, then an address past the store
        set_sizes(12'd4095, 12'd4095, 12'd3, 12'd3);
        fetch_pixel(11'd2, 11'd0);
        fetch_pixel(11'd2, 11'd2);
        fetch_pixel(11'd0, 11'd0);
    endtask

    task automatic test_zero_target();
        set_sizes(12'd16, 12'd16, 12'd0, 12'd8);
        fetch_pixel(11'd0, 11'd0);
        fetch_pixel(11'd5, 11'd3);
        set_sizes(12'd16, 12'd16, 12'd8, 12'd0);
        fetch_pixel(11'd0, 11'd0);
        fetch_pixel(11'd7, 11'd2);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return SIZE_W'($urandom_range(1, 48));
        if (roll < 9)
            return SIZE_W'($urandom_range(1, MAX_DIMENSION));
        return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input logic [SIZE_W-1:0] limit);
        if (limit == 0)
            return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, (limit > MAX_DIMENSION) ? MAX_DIMENSION - 1
                                                                  : limit - 1));
    endfunction

    task automatic test_random_scaling();
        int              roll;
        longint unsigned area;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0)
                set_sizes(12'd2048, 12'd2048, 12'd2048, 12'd2048);
            else if (phase == 1)
                set_sizes(12'd1, 12'd1, 12'd1, 12'd1);
            else
                set_sizes(pick_size(), pick_size(), pick_size(), pick_size());
            area = 64'(source_cols) * 64'(source_rows);
            for (int n = 0; n < 170; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 20 && area != 0 && area <= STORE_PIXELS)
                    load_pixel(INDEX_W'($urandom_range(0, 32'(area - 1))),
                               PIXEL_W'($urandom));
                else if (roll < 30)
                    load_pixel(INDEX_W'($urandom), PIXEL_W'($urandom));
                else if (roll < 90)
                    fetch_pixel(pick_coord(tgt_width), pick_coord(tgt_height));
                else
                    fetch_pixel(COORD_W'($urandom), COORD_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_sizes();
        test_field_extremes();
        test_zero_target();
        test_random_scaling();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== nearest_neighbor_scaler.f =====
hdl/nns_pkg.sv
hdl/nns_step_div.sv
hdl/nns_front.sv
hdl/nns_queue.sv
hdl/nns_back.sv
hdl/nearest_neighbor_scaler.sv
tb/testbench.sv
